/* design/bgpl_pkg.sv */
// ============================================================================
// bgpl_pkg
// Shared types, constants and codes of the beam grid path length block.
// ============================================================================
`default_nettype none

package bgpl_pkg;

    // grid size limits
    localparam int MAX_ROWS   = 32;
    localparam int MAX_COLS   = 32;

    // internal widths
    localparam int CNT_W      = 7;      // clamped row / column counts
    localparam int IDX_W      = 7;      // signed grid line index, -1 .. 32
    localparam int COL_W      = 6;      // cell column / row
    localparam int POS_W      = 24;     // grid line position, Q16.8 signed
    localparam int LEN_W      = 25;     // beam length, Q.16
    localparam int SQ_W       = 50;     // square root operand
    localparam int SQ_TOP     = 48;     // first trial bit of the root
    localparam int PROD_W     = 32;     // 16 x 16 products
    localparam int MUL_W      = 41;     // 16 x 25 partial products
    localparam int NUM_W      = 58;     // divider dividend
    localparam int Q_W        = 17;     // segment length quotient
    localparam int DIV_CNT_W  = 5;

    localparam int XING_LIMIT = 63;     // crossings used per beam
    localparam int XING_CNT_W = 6;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    localparam int CFG_IDX_W  = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_X     = 3'd0,
        REG_MAX_X     = 3'd1,
        REG_MIN_Y     = 3'd2,
        REG_MAX_Y     = 3'd3,
        REG_CELL_EDGE = 3'd4,
        REG_ROW_COUNT = 3'd5,
        REG_COL_COUNT = 3'd6
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_OOB     = 2'd2
    } status_t;

    typedef struct packed {
        logic [15:0] start_x;
        logic [15:0] start_y;
        logic [15:0] end_x;
        logic [15:0] end_y;
        logic        reading_valid;
    } beam_t;

    typedef struct packed {
        logic [9:0]  cell_index;
        logic [16:0] path_length;
        status_t     status;
        logic        last_of_beam;
    } result_t;

    typedef struct packed {
        logic [15:0] min_x;
        logic [15:0] max_x;
        logic [15:0] min_y;
        logic [15:0] max_y;
        logic [14:0] cell_edge;
        logic [5:0]  row_count;
        logic [5:0]  col_count;
    } cfg_t;

    // one queue entry: end of a segment at t = a / b
    typedef struct packed {
        logic [15:0]      a;
        logic [15:0]      b;
        logic [LEN_W-1:0] len16;
        logic [9:0]       cell_index;
        logic             last;
        status_t          status;
    } xing_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_ERR,
        F_SCAN
    } front_state_t;

    typedef enum logic [1:0] {
        SQ_IDLE,
        SQ_LOAD,
        SQ_RUN
    } sq_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL,
        B_WIDE,
        B_SUM,
        B_DIV
    } back_state_t;

endpackage

`default_nettype wire

/* design/bgpl_sqrt.sv */
// ============================================================================
// bgpl_sqrt
// Bit-serial integer square root of (adx^2 + ady^2) * 65536.
// ============================================================================
`default_nettype none

module bgpl_sqrt (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [15:0]               adx,
    input  wire logic [15:0]               ady,
    output logic                           done,
    output logic [bgpl_pkg::LEN_W-1:0]     root
);
    import bgpl_pkg::*;

    sq_state_t         state_reg, state_next;
    logic [15:0]       adx_reg, adx_next;
    logic [15:0]       ady_reg, ady_next;
    logic [SQ_W-1:0]   v_reg, v_next;
    logic [SQ_W-1:0]   r_reg, r_next;
    logic [SQ_W-1:0]   bit_reg, bit_next;

    logic [PROD_W-1:0] sqa, sqb;
    logic [PROD_W:0]   sq_sum;
    logic [SQ_W-1:0]   trial;

    assign sqa    = adx_reg * adx_reg;
    assign sqb    = ady_reg * ady_reg;
    assign sq_sum = {1'b0, sqa} + {1'b0, sqb};
    assign trial  = r_reg + bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SQ_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        adx_reg <= adx_next;
        ady_reg <= ady_next;
        v_reg   <= v_next;
        r_reg   <= r_next;
        bit_reg <= bit_next;
    end

    always_comb
    begin
        state_next = state_reg;
        adx_next   = adx_reg;
        ady_next   = ady_reg;
        v_next     = v_reg;
        r_next     = r_reg;
        bit_next   = bit_reg;
        case (state_reg)
            SQ_IDLE:
            begin
                if (start)
                begin
                    adx_next   = adx;
                    ady_next   = ady;
                    state_next = SQ_LOAD;
                end
            end
            SQ_LOAD:
            begin
                v_next           = SQ_W'({sq_sum, 16'h0000});
                r_next           = '0;
                bit_next         = '0;
                bit_next[SQ_TOP] = 1'b1;
                state_next       = SQ_RUN;
            end
            SQ_RUN:
            begin
                if (v_reg >= trial)
                begin
                    v_next = v_reg - trial;
                    r_next = (r_reg >> 1) + bit_reg;
                end
                else
                begin
                    r_next = r_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (bit_reg[0])
                begin
                    state_next = SQ_IDLE;
                end
            end
            default:
            begin
                state_next = SQ_IDLE;
            end
        endcase
    end

    assign done = (state_reg == SQ_IDLE);
    assign root = r_reg[LEN_W-1:0];

endmodule

`default_nettype wire

/* design/bgpl_front.sv */
// ============================================================================
// bgpl_front
// Beam intake: error checks, grid line scan and merge of crossings by t.
// ============================================================================
`default_nettype none

module bgpl_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire bgpl_pkg::beam_t   beam,
    input  wire bgpl_pkg::cfg_t    cfg,
    output logic                   push,
    output bgpl_pkg::xing_t        push_data,
    input  wire logic              full
);
    import bgpl_pkg::*;

    function automatic logic signed [POS_W-1:0] sext(input logic [15:0] v);
        return $signed({{(POS_W-16){v[15]}}, v});
    endfunction

    function automatic logic [CNT_W-1:0] clamp_cnt(input logic [5:0] v,
                                                   input logic [CNT_W-1:0] maxv);
        logic [CNT_W-1:0] w;
        w = {{(CNT_W-6){1'b0}}, v};
        if (w == '0)
            return CNT_W'(1);
        else if (w > maxv)
            return maxv;
        else
            return w;
    endfunction

    front_state_t                   state_reg, state_next;
    status_t                        err_reg, err_next;
    logic [15:0]                    sx_reg, sx_next, sy_reg, sy_next;
    logic [15:0]                    lox_reg, lox_next, hix_reg, hix_next;
    logic [15:0]                    loy_reg, loy_next, hiy_reg, hiy_next;
    logic [15:0]                    adx_reg, adx_next, ady_reg, ady_next;
    logic                           xneg_reg, xneg_next, yneg_reg, yneg_next;
    logic [IDX_W-1:0]               hx_reg, hx_next, hy_reg, hy_next;
    logic signed [POS_W-1:0]        px_reg, px_next, py_reg, py_next;
    logic [XING_CNT_W-1:0]          n_reg, n_next;

    // configuration as used
    logic [14:0]                    edge_c;
    logic [CNT_W-1:0]               rows_c, cols_c, rows_m1, cols_m1;
    logic [CNT_W+14:0]              xoff, yoff;
    logic signed [POS_W-1:0]        edge_p;

    // intake
    logic signed [16:0]             dx_w, dy_w;
    logic [15:0]                    adx_w, ady_w;
    logic                           err_inv, err_oob, acc;

    // scanners
    logic                           xidx_ok, yidx_ok;
    logic                           x_le, x_ge, y_le, y_ge;
    logic                           x_skip, x_done, x_qual;
    logic                           y_skip, y_done, y_qual;
    logic [IDX_W-1:0]               hx_adv, hy_adv;
    logic signed [POS_W-1:0]        px_adv, py_adv, dxp, dyp;
    logic [15:0]                    ax, ay;
    logic [PROD_W-1:0]              prod_x, prod_y;
    logic [COL_W-1:0]               col, row;
    logic [COL_W+CNT_W-1:0]         idx_full;
    logic                           lim, sq_done;
    logic [LEN_W-1:0]               len16;

    assign edge_c  = (cfg.cell_edge == '0) ? 15'd1 : cfg.cell_edge;
    assign rows_c  = clamp_cnt(cfg.row_count, CNT_W'(MAX_ROWS));
    assign cols_c  = clamp_cnt(cfg.col_count, CNT_W'(MAX_COLS));
    assign rows_m1 = rows_c - 1'b1;
    assign cols_m1 = cols_c - 1'b1;
    assign xoff    = cols_m1 * edge_c;
    assign yoff    = rows_m1 * edge_c;
    assign edge_p  = $signed({{(POS_W-15){1'b0}}, edge_c});

    assign dx_w  = $signed({beam.end_x[15], beam.end_x})
                 - $signed({beam.start_x[15], beam.start_x});
    assign dy_w  = $signed({beam.end_y[15], beam.end_y})
                 - $signed({beam.start_y[15], beam.start_y});
    assign adx_w = dx_w[16] ? 16'(-dx_w) : dx_w[15:0];
    assign ady_w = dy_w[16] ? 16'(-dy_w) : dy_w[15:0];

    assign err_inv = !beam.reading_valid
                   || ((beam.start_x == beam.end_x) && (beam.start_y == beam.end_y));
    assign err_oob = ($signed(beam.start_x) < $signed(cfg.min_x))
                   || ($signed(beam.end_x)   < $signed(cfg.min_x))
                   || ($signed(beam.start_x) > $signed(cfg.max_x))
                   || ($signed(beam.end_x)   > $signed(cfg.max_x))
                   || ($signed(beam.start_y) < $signed(cfg.min_y))
                   || ($signed(beam.end_y)   < $signed(cfg.min_y))
                   || ($signed(beam.start_y) > $signed(cfg.max_y))
                   || ($signed(beam.end_y)   > $signed(cfg.max_y));

    assign acc  = start && (state_reg == F_IDLE);
    assign busy = (state_reg != F_IDLE);

    bgpl_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (acc && !err_inv && !err_oob),
        .adx   (adx_w),
        .ady   (ady_w),
        .done  (sq_done),
        .root  (len16)
    );

    // x lines: head is the next line to cross in travel direction
    assign xidx_ok = !hx_reg[IDX_W-1] && (hx_reg < IDX_W'(cols_c));
    assign x_le    = px_reg <= sext(lox_reg);
    assign x_ge    = px_reg >= sext(hix_reg);
    assign x_skip  = xidx_ok && (xneg_reg ? x_ge : x_le);
    assign x_done  = !xidx_ok || (!x_skip && (xneg_reg ? x_le : x_ge));
    assign x_qual  = !x_skip && !x_done;
    assign hx_adv  = xneg_reg ? hx_reg - 1'b1 : hx_reg + 1'b1;
    assign px_adv  = xneg_reg ? px_reg - edge_p : px_reg + edge_p;

    assign yidx_ok = !hy_reg[IDX_W-1] && (hy_reg < IDX_W'(rows_c));
    assign y_le    = py_reg <= sext(loy_reg);
    assign y_ge    = py_reg >= sext(hiy_reg);
    assign y_skip  = yidx_ok && (yneg_reg ? y_ge : y_le);
    assign y_done  = !yidx_ok || (!y_skip && (yneg_reg ? y_le : y_ge));
    assign y_qual  = !y_skip && !y_done;
    assign hy_adv  = yneg_reg ? hy_reg - 1'b1 : hy_reg + 1'b1;
    assign py_adv  = yneg_reg ? py_reg - edge_p : py_reg + edge_p;

    // distance of the head lines from the start point
    assign dxp = px_reg - sext(sx_reg);
    assign dyp = py_reg - sext(sy_reg);
    assign ax  = dxp[POS_W-1] ? 16'(-dxp) : dxp[15:0];
    assign ay  = dyp[POS_W-1] ? 16'(-dyp) : dyp[15:0];

    // ax/adx against ay/ady
    assign prod_x = ax * ady_reg;
    assign prod_y = ay * adx_reg;

    // cell of the current segment
    always_comb
    begin
        if (xneg_reg)
            col = hx_reg[IDX_W-1] ? '0 : COL_W'(hx_reg);
        else
            col = (hx_reg == '0) ? '0 : COL_W'(hx_reg - 1'b1);
        if (yneg_reg)
            row = hy_reg[IDX_W-1] ? '0 : COL_W'(hy_reg);
        else
            row = (hy_reg == '0) ? '0 : COL_W'(hy_reg - 1'b1);
    end

    assign idx_full = col * rows_c + {{(CNT_W){1'b0}}, row};
    assign lim      = (n_reg == XING_CNT_W'(XING_LIMIT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        err_reg  <= err_next;
        sx_reg   <= sx_next;
        sy_reg   <= sy_next;
        lox_reg  <= lox_next;
        hix_reg  <= hix_next;
        loy_reg  <= loy_next;
        hiy_reg  <= hiy_next;
        adx_reg  <= adx_next;
        ady_reg  <= ady_next;
        xneg_reg <= xneg_next;
        yneg_reg <= yneg_next;
        hx_reg   <= hx_next;
        hy_reg   <= hy_next;
        px_reg   <= px_next;
        py_reg   <= py_next;
        n_reg    <= n_next;
    end

    always_comb
    begin
        state_next = state_reg;
        err_next   = err_reg;
        sx_next    = sx_reg;
        sy_next    = sy_reg;
        lox_next   = lox_reg;
        hix_next   = hix_reg;
        loy_next   = loy_reg;
        hiy_next   = hiy_reg;
        adx_next   = adx_reg;
        ady_next   = ady_reg;
        xneg_next  = xneg_reg;
        yneg_next  = yneg_reg;
        hx_next    = hx_reg;
        hy_next    = hy_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        n_next     = n_reg;

        push                 = 1'b0;
        push_data.a          = ax;
        push_data.b          = adx_reg;
        push_data.len16      = len16;
        push_data.cell_index = idx_full[9:0];
        push_data.last       = 1'b0;
        push_data.status     = ST_OK;

        case (state_reg)
            F_IDLE:
            begin
                if (acc)
                begin
                    sx_next   = beam.start_x;
                    sy_next   = beam.start_y;
                    adx_next  = adx_w;
                    ady_next  = ady_w;
                    xneg_next = dx_w[16];
                    yneg_next = dy_w[16];
                    lox_next  = dx_w[16] ? beam.end_x : beam.start_x;
                    hix_next  = dx_w[16] ? beam.start_x : beam.end_x;
                    loy_next  = dy_w[16] ? beam.end_y : beam.start_y;
                    hiy_next  = dy_w[16] ? beam.start_y : beam.end_y;
                    hx_next   = dx_w[16] ? IDX_W'(cols_m1) : '0;
                    hy_next   = dy_w[16] ? IDX_W'(rows_m1) : '0;
                    px_next   = sext(cfg.min_x);
                    py_next   = sext(cfg.min_y);
                    if (dx_w[16])
                        px_next = sext(cfg.min_x)
                                + $signed({{(POS_W-CNT_W-15){1'b0}}, xoff});
                    if (dy_w[16])
                        py_next = sext(cfg.min_y)
                                + $signed({{(POS_W-CNT_W-15){1'b0}}, yoff});
                    n_next    = '0;
                    if (err_inv)
                    begin
                        err_next   = ST_INVALID;
                        state_next = F_ERR;
                    end
                    else if (err_oob)
                    begin
                        err_next   = ST_OOB;
                        state_next = F_ERR;
                    end
                    else
                    begin
                        state_next = F_SCAN;
                    end
                end
            end
            F_ERR:
            begin
                if (!full)
                begin
                    push                 = 1'b1;
                    push_data.cell_index = '0;
                    push_data.last       = 1'b1;
                    push_data.status     = err_reg;
                    state_next           = F_IDLE;
                end
            end
            F_SCAN:
            begin
                // step past lines outside the beam's span first
                if (x_skip)
                begin
                    hx_next = hx_adv;
                    px_next = px_adv;
                end
                if (y_skip)
                begin
                    hy_next = hy_adv;
                    py_next = py_adv;
                end
                if (!x_skip && !y_skip && sq_done && !full)
                begin
                    push = 1'b1;
                    if ((x_done && y_done) || lim)
                    begin
                        // segment ending at the end point
                        push_data.a    = 16'd1;
                        push_data.b    = 16'd1;
                        push_data.last = 1'b1;
                        state_next     = F_IDLE;
                    end
                    else
                    begin
                        n_next = n_reg + 1'b1;
                        if (x_qual && (y_done || (prod_x < prod_y)))
                        begin
                            hx_next = hx_adv;
                            px_next = px_adv;
                        end
                        else if (y_qual && (x_done || (prod_y < prod_x)))
                        begin
                            push_data.a = ay;
                            push_data.b = ady_reg;
                            hy_next     = hy_adv;
                            py_next     = py_adv;
                        end
                        else
                        begin
                            // corner: both lines at the same t
                            hx_next = hx_adv;
                            px_next = px_adv;
                            hy_next = hy_adv;
                            py_next = py_adv;
                        end
                    end
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* design/bgpl_fifo.sv */
// ============================================================================
// bgpl_fifo
// Short crossing queue between the front and the back.
// ============================================================================
`default_nettype none

module bgpl_fifo (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire bgpl_pkg::xing_t   din,
    output logic                   full,
    input  wire logic              pop,
    output bgpl_pkg::xing_t        dout,
    output logic                   empty
);
    import bgpl_pkg::*;

    xing_t                mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_reg, wr_next, rd_reg, rd_next;
    logic [FIFO_AW:0]     cnt_reg, cnt_next;
    logic                 do_push, do_pop;

    assign full    = (cnt_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem[rd_reg];

    always_comb
    begin
        wr_next  = do_push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = do_pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (!do_push && do_pop)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_reg] <= din;
        end
    end

endmodule

`default_nettype wire

/* design/bgpl_back.sv */
// ============================================================================
// bgpl_back
// Segment length: (t2 - t1) * L16 / 256, rounded, by a serial divider.
// ============================================================================
`default_nettype none

module bgpl_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              empty,
    output logic                   pop,
    input  wire bgpl_pkg::xing_t   head,
    output logic                   result_valid,
    output bgpl_pkg::result_t      result
);
    import bgpl_pkg::*;

    back_state_t            state_reg, state_next;
    xing_t                  ent_reg, ent_next;
    logic [15:0]            pa_reg, pa_next, pb_reg, pb_next;
    logic [PROD_W-1:0]      p1_reg, p1_next, p2_reg, p2_next;
    logic [PROD_W-1:0]      den_reg, den_next;
    logic [MUL_W-1:0]       mlo_reg, mlo_next, mhi_reg, mhi_next;
    logic [NUM_W-1:0]       rem_reg, rem_next, dsh_reg, dsh_next;
    logic [Q_W-1:0]         q_reg, q_next;
    logic [DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                   vld_reg, vld_next;
    result_t                res_reg, res_next;

    logic [PROD_W-1:0]      diff;
    logic                   ge;

    assign diff = p1_reg - p2_reg;
    assign ge   = (rem_reg >= dsh_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            vld_reg   <= 1'b0;
            pa_reg    <= '0;
            pb_reg    <= 16'd1;
        end
        else
        begin
            state_reg <= state_next;
            vld_reg   <= vld_next;
            pa_reg    <= pa_next;
            pb_reg    <= pb_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
        p1_reg  <= p1_next;
        p2_reg  <= p2_next;
        den_reg <= den_next;
        mlo_reg <= mlo_next;
        mhi_reg <= mhi_next;
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
        cnt_reg <= cnt_next;
        res_reg <= res_next;
    end

    always_comb
    begin
        state_next = state_reg;
        ent_next   = ent_reg;
        pa_next    = pa_reg;
        pb_next    = pb_reg;
        p1_next    = p1_reg;
        p2_next    = p2_reg;
        den_next   = den_reg;
        mlo_next   = mlo_reg;
        mhi_next   = mhi_reg;
        rem_next   = rem_reg;
        dsh_next   = dsh_reg;
        q_next     = q_reg;
        cnt_next   = cnt_reg;
        res_next   = res_reg;
        vld_next   = 1'b0;
        pop        = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                if (!empty)
                begin
                    pop      = 1'b1;
                    ent_next = head;
                    if (head.status != ST_OK)
                    begin
                        res_next.cell_index   = '0;
                        res_next.path_length  = '0;
                        res_next.status       = head.status;
                        res_next.last_of_beam = 1'b1;
                        vld_next              = 1'b1;
                        pa_next               = '0;
                        pb_next               = 16'd1;
                    end
                    else
                    begin
                        state_next = B_MUL;
                    end
                end
            end
            B_MUL:
            begin
                p1_next    = ent_reg.a * pb_reg;
                p2_next    = pa_reg * ent_reg.b;
                den_next   = pb_reg * ent_reg.b;
                state_next = B_WIDE;
            end
            B_WIDE:
            begin
                mlo_next   = diff[15:0] * ent_reg.len16;
                mhi_next   = diff[31:16] * ent_reg.len16;
                state_next = B_SUM;
            end
            B_SUM:
            begin
                // dividend carries half the divisor for rounding
                rem_next   = (NUM_W'(mhi_reg) << 16) + NUM_W'(mlo_reg)
                           + (NUM_W'(den_reg) << 7);
                dsh_next   = NUM_W'(den_reg) << (8 + Q_W - 1);
                q_next     = '0;
                cnt_next   = '0;
                state_next = B_DIV;
            end
            B_DIV:
            begin
                // quotient stays below 2^17 since t2 - t1 <= 1
                if (ge)
                    rem_next = rem_reg - dsh_reg;
                q_next   = {q_reg[Q_W-2:0], ge};
                dsh_next = dsh_reg >> 1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(Q_W - 1))
                begin
                    res_next.cell_index   = ent_reg.cell_index;
                    res_next.path_length  = {q_reg[Q_W-2:0], ge};
                    res_next.status       = ST_OK;
                    res_next.last_of_beam = ent_reg.last;
                    vld_next              = 1'b1;
                    pa_next               = ent_reg.last ? '0 : ent_reg.a;
                    pb_next               = ent_reg.last ? 16'd1 : ent_reg.b;
                    state_next            = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    assign result_valid = vld_reg;
    assign result       = res_reg;

endmodule

`default_nettype wire

/* design/beam_grid_path_lengths_top.sv */
// ============================================================================
// beam_grid_path_lengths_top
// Path lengths of a straight beam through a uniform square grid.
// ============================================================================
// Usage:
//   Beam in: drive beam and raise start; the transaction is taken at a rising
//   edge with start high and busy low. busy stays high while the front end
//   scans grid lines and merges crossings for that beam.
//   Results out: one transaction per segment on result, marked by a one-cycle
//   result_valid strobe; the receiver cannot stall, so nothing backs up past
//   the output register. The last segment of a beam has last_of_beam set.
//   A bad reading, zero length or out-of-bounds beam gives one status result.
//   Configuration: cfg_valid/cfg_ready write channel, cfg_index selects the
//   register; cfg_ready is always high. Write only while the block is idle.
// Timing:
//   Front: the length root is serial (one bit pair per cycle), with line
//   skipping on both axes running alongside it, then one crossing per cycle
//   into a four-entry queue while the queue is not full. Back: each segment
//   passes the multiply, widen and sum states and the 17-step serial divider
//   before the next queue entry is popped. An error beam goes from the front
//   error state through the queue to the back end's result register.
// Reset: rst_n clears all control state and loads the default grid.
// ============================================================================
`default_nettype none

module beam_grid_path_lengths_top (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire bgpl_pkg::beam_t                    beam,
    output logic                                    result_valid,
    output bgpl_pkg::result_t                       result,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [bgpl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [15:0]                        cfg_data
);
    import bgpl_pkg::*;

    cfg_t    cfg_reg, cfg_next;
    logic    push, full, pop, empty;
    xing_t   push_data, head;

    // configuration registers; writes beyond the list are dropped
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_MIN_X:     cfg_next.min_x     = cfg_data;
                REG_MAX_X:     cfg_next.max_x     = cfg_data;
                REG_MIN_Y:     cfg_next.min_y     = cfg_data;
                REG_MAX_Y:     cfg_next.max_y     = cfg_data;
                REG_CELL_EDGE: cfg_next.cell_edge = cfg_data[14:0];
                REG_ROW_COUNT: cfg_next.row_count = cfg_data[5:0];
                REG_COL_COUNT: cfg_next.col_count = cfg_data[5:0];
                default:       cfg_next           = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_x     <= 16'd0;
            cfg_reg.max_x     <= 16'd8192;
            cfg_reg.min_y     <= 16'd0;
            cfg_reg.max_y     <= 16'd8192;
            cfg_reg.cell_edge <= 15'd256;
            cfg_reg.row_count <= 6'd32;
            cfg_reg.col_count <= 6'd32;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front end: checks, line scan, merge by t
    bgpl_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .beam      (beam),
        .cfg       (cfg_reg),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    // crossing queue
    bgpl_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (push_data),
        .full  (full),
        .pop   (pop),
        .dout  (head),
        .empty (empty)
    );

    // back end: segment lengths and result register
    bgpl_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .empty        (empty),
        .pop          (pop),
        .head         (head),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

`default_nettype wire
